FILE: rtl/irps_pkg.sv
// Shared types, constants and field layout for the ICSP record program sequencer.
package irps_pkg;

   localparam int ADDRESS_BITS   = 22;
   localparam int CFG_BASE_BITS  = 22;
   localparam int LENGTH_BITS    = 8;
   localparam int BYTE_BITS      = 8;
   localparam int WORD_BITS      = 16;
   localparam int CMD_BITS       = 4;
   localparam int PTR_BITS       = 24;
   localparam int CMP_BITS       = (ADDRESS_BITS > CFG_BASE_BITS) ? ADDRESS_BITS : CFG_BASE_BITS;

   localparam int REQ_FIELD_BITS = BYTE_BITS + ADDRESS_BITS + LENGTH_BITS;
   localparam int REQ_DATA_BITS  = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = CMD_BITS + WORD_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_USER_BITS  = 3;

   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = CFG_BASE_BITS;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_BITS-1:0] REG_CONFIG_BASE = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_MAX_LENGTH  = 1'd1;

   localparam logic [CFG_BASE_BITS-1:0] CONFIG_BASE_RESET = 22'h300000;
   localparam logic [LENGTH_BITS-1:0]   MAX_LENGTH_RESET  = 8'd32;

   localparam logic [CMD_BITS-1:0] CMD_CORE           = 4'h0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE_POSTINC2 = 4'hd;
   localparam logic [CMD_BITS-1:0] CMD_START_PROG     = 4'hf;

   localparam logic [WORD_BITS-1:0] OP_BSF_EECON1_EEPGD = 16'h8ea6;
   localparam logic [WORD_BITS-1:0] OP_BSF_EECON1_CFGS  = 16'h8ca6;
   localparam logic [WORD_BITS-1:0] OP_BCF_EECON1_CFGS  = 16'h9ca6;
   localparam logic [BYTE_BITS-1:0] OP_MOVLW_HIGH       = 8'h0e;
   localparam logic [WORD_BITS-1:0] OP_MOVWF_TBLPTRU    = 16'h6ef8;
   localparam logic [WORD_BITS-1:0] OP_MOVWF_TBLPTRH    = 16'h6ef7;
   localparam logic [WORD_BITS-1:0] OP_MOVWF_TBLPTRL    = 16'h6ef6;
   localparam logic [BYTE_BITS-1:0] PAD_BYTE            = 8'hff;

   typedef enum logic [1:0] {
      ERR_NONE       = 2'd0,
      ERR_TOO_LONG   = 2'd1,
      ERR_ODD_LENGTH = 2'd2,
      ERR_ODD_START  = 2'd3
   } err_type;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_CFG  = 2'd1,
      MODE_LOW  = 2'd2,
      MODE_HIGH = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PRE_NONE,
      PRE_CFG,
      PRE_CODE
   } pre_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_START,
      FIN_POSTINC
   } fin_type;

   typedef enum logic [3:0] {
      STEP_ERR,
      STEP_PRE0,
      STEP_PRE1,
      STEP_PTR0,
      STEP_PTR1,
      STEP_PTR2,
      STEP_PTR3,
      STEP_PTR4,
      STEP_PTR5,
      STEP_FIN,
      STEP_HOLD
   } step_type;

   // One unit of work for the back end: everything one input byte asks for.
   typedef struct packed {
      err_type                 err;
      pre_type                 pre;
      logic                    load_ptr;
      fin_type                 fin;
      logic [ADDRESS_BITS-1:0] addr;
      logic [WORD_BITS-1:0]    word;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_msg_type;

endpackage

FILE: rtl/irps_front.sv
// Front end: accepts record bytes, tracks the record mode and classifies each byte into a job.
module irps_front (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [irps_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                               req_tuser,
   input  logic                               req_tlast,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [irps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [irps_pkg::CSR_DATA_BITS-1:0] csr_data,
   input  logic                               queue_full,
   output irps_pkg::job_msg_type              push_msg
);
   import irps_pkg::*;

   mode_type                 mode_ff, mode_in;
   logic [BYTE_BITS-1:0]     held_ff, held_in;
   logic [CFG_BASE_BITS-1:0] config_base_ff;
   logic [LENGTH_BITS-1:0]   max_len_ff;

   logic [BYTE_BITS-1:0]    data_byte;
   logic [ADDRESS_BITS-1:0] byte_address;
   logic [LENGTH_BITS-1:0]  record_length;
   logic                    accept;
   logic                    in_config;
   logic [WORD_BITS-1:0]    cfg_word;

   assign data_byte     = req_tdata[BYTE_BITS-1:0];
   assign byte_address  = req_tdata[BYTE_BITS +: ADDRESS_BITS];
   assign record_length = req_tdata[BYTE_BITS + ADDRESS_BITS +: LENGTH_BITS];

   assign req_tready = !queue_full;
   assign csr_ready  = 1'b1;
   assign accept     = req_tvalid && req_tready;
   assign in_config  = CMP_BITS'(byte_address) >= CMP_BITS'(config_base_ff);
   assign cfg_word   = byte_address[0] ? {data_byte, 8'h00} : {8'h00, data_byte};

   always_ff @(posedge clock) begin
      if (reset) begin
         config_base_ff <= CONFIG_BASE_RESET;
         max_len_ff     <= MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_CONFIG_BASE: config_base_ff <= csr_data;
            REG_MAX_LENGTH:  max_len_ff     <= csr_data[LENGTH_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         held_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         held_ff <= held_in;
      end
   end

   always_comb begin
      mode_in               = mode_ff;
      held_in               = held_ff;
      push_msg.valid        = 1'b0;
      push_msg.job.err      = ERR_NONE;
      push_msg.job.pre      = PRE_NONE;
      push_msg.job.load_ptr = 1'b0;
      push_msg.job.fin      = FIN_NONE;
      push_msg.job.addr     = byte_address;
      push_msg.job.word     = cfg_word;
      if (accept) begin
         if (req_tuser) begin
            mode_in = MODE_IDLE;
            if (record_length == '0) begin
               // empty record: nothing to write
            end else if (record_length > max_len_ff) begin
               push_msg.valid   = 1'b1;
               push_msg.job.err = ERR_TOO_LONG;
            end else if (in_config) begin
               push_msg.valid        = 1'b1;
               push_msg.job.pre      = PRE_CFG;
               push_msg.job.load_ptr = 1'b1;
               push_msg.job.fin      = FIN_START;
               mode_in               = req_tlast ? MODE_IDLE : MODE_CFG;
            end else if (record_length[0]) begin
               push_msg.valid   = 1'b1;
               push_msg.job.err = ERR_ODD_LENGTH;
            end else if (byte_address[0]) begin
               push_msg.valid   = 1'b1;
               push_msg.job.err = ERR_ODD_START;
            end else begin
               push_msg.valid        = 1'b1;
               push_msg.job.pre      = PRE_CODE;
               push_msg.job.load_ptr = 1'b1;
               push_msg.job.word     = {PAD_BYTE, data_byte};
               if (req_tlast) begin
                  push_msg.job.fin = FIN_START;
               end else begin
                  held_in = data_byte;
                  mode_in = MODE_HIGH;
               end
            end
         end else begin
            case (mode_ff)
               MODE_CFG: begin
                  push_msg.valid        = 1'b1;
                  push_msg.job.load_ptr = 1'b1;
                  push_msg.job.fin      = FIN_START;
                  if (req_tlast) mode_in = MODE_IDLE;
               end
               MODE_LOW: begin
                  if (req_tlast) begin
                     push_msg.valid    = 1'b1;
                     push_msg.job.fin  = FIN_START;
                     push_msg.job.word = {PAD_BYTE, data_byte};
                     mode_in           = MODE_IDLE;
                  end else begin
                     held_in = data_byte;
                     mode_in = MODE_HIGH;
                  end
               end
               MODE_HIGH: begin
                  push_msg.valid    = 1'b1;
                  push_msg.job.word = {data_byte, held_ff};
                  if (req_tlast) begin
                     push_msg.job.fin = FIN_START;
                     mode_in          = MODE_IDLE;
                  end else begin
                     push_msg.job.fin = FIN_POSTINC;
                     mode_in          = MODE_LOW;
                  end
               end
               default: ;  // idle: drop stray bytes
            endcase
         end
      end
   end

endmodule

FILE: rtl/irps_queue.sv
// Short job queue between the front and back ends.
module irps_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  irps_pkg::job_msg_type push_msg,
   output logic                  full,
   output irps_pkg::job_msg_type head_msg,
   input  logic                  pop
);
   import irps_pkg::*;

   job_type                   mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full           = count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH);
   assign head_msg.valid = count_ff != '0;
   assign head_msg.job   = mem_ff[rd_ptr_ff];
   assign do_push        = push_msg.valid && !full;
   assign do_pop         = pop && head_msg.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) wr_ptr_in = wr_ptr_ff + 1'b1;
      if (do_pop)  rd_ptr_in = rd_ptr_ff + 1'b1;
      if (do_push && !do_pop) count_in = count_ff + 1'b1;
      else if (!do_push && do_pop) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_msg.job;
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_pop_lowers: assert property (@(posedge clock) disable iff (reset)
      (do_pop && !do_push) |=> count_ff == $past(count_ff) - 1'b1)
      else $error("queue count not lowered on pop");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree when empty");
`endif

endmodule

FILE: rtl/irps_back.sv
// Back end: expands each job into ICSP command and operand words through an output register.
module irps_back (
   input  logic                               clock,
   input  logic                               reset,
   input  irps_pkg::job_msg_type              head_msg,
   output logic                               pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [irps_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic [irps_pkg::RSP_USER_BITS-1:0] rsp_tuser,
   output logic                               rsp_tlast
);
   import irps_pkg::*;

   step_type             step_ff, step_in, step_next, step_first;
   logic                 active_ff, active_in;
   job_type              job_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [CMD_BITS-1:0]  cmd_ff;
   logic [WORD_BITS-1:0] operand_ff;
   logic                 hold_ff;
   err_type              err_ff;
   logic                 last_ff;

   logic [CMD_BITS-1:0]  cmd;
   logic [WORD_BITS-1:0] operand;
   logic                 hold;
   err_type              err;
   logic                 is_last;
   logic                 advance;
   logic [PTR_BITS-1:0]  ptr;

   assign ptr     = PTR_BITS'(job_ff.addr);
   assign advance = active_ff && (!rsp_valid_ff || rsp_tready);
   assign pop     = head_msg.valid && (!active_ff || (advance && is_last));

   always_comb begin
      if (head_msg.job.err != ERR_NONE)      step_first = STEP_ERR;
      else if (head_msg.job.pre != PRE_NONE) step_first = STEP_PRE0;
      else if (head_msg.job.load_ptr)        step_first = STEP_PTR0;
      else                                   step_first = STEP_FIN;
   end

   // word generator for the current step
   always_comb begin
      cmd       = CMD_CORE;
      operand   = '0;
      hold      = 1'b0;
      err       = ERR_NONE;
      is_last   = 1'b0;
      step_next = step_ff;
      case (step_ff)
         STEP_ERR: begin
            err     = job_ff.err;
            is_last = 1'b1;
         end
         STEP_PRE0: begin
            operand   = OP_BSF_EECON1_EEPGD;
            step_next = STEP_PRE1;
         end
         STEP_PRE1: begin
            operand   = (job_ff.pre == PRE_CODE) ? OP_BCF_EECON1_CFGS : OP_BSF_EECON1_CFGS;
            step_next = STEP_PTR0;
         end
         STEP_PTR0: begin
            operand   = {OP_MOVLW_HIGH, ptr[23:16]};
            step_next = STEP_PTR1;
         end
         STEP_PTR1: begin
            operand   = OP_MOVWF_TBLPTRU;
            step_next = STEP_PTR2;
         end
         STEP_PTR2: begin
            operand   = {OP_MOVLW_HIGH, ptr[15:8]};
            step_next = STEP_PTR3;
         end
         STEP_PTR3: begin
            operand   = OP_MOVWF_TBLPTRH;
            step_next = STEP_PTR4;
         end
         STEP_PTR4: begin
            operand   = {OP_MOVLW_HIGH, ptr[7:0]};
            step_next = STEP_PTR5;
         end
         STEP_PTR5: begin
            operand = OP_MOVWF_TBLPTRL;
            if (job_ff.fin == FIN_NONE) is_last = 1'b1;
            else step_next = STEP_FIN;
         end
         STEP_FIN: begin
            operand = job_ff.word;
            if (job_ff.fin == FIN_START) begin
               cmd       = CMD_START_PROG;
               step_next = STEP_HOLD;
            end else begin
               cmd     = CMD_WRITE_POSTINC2;
               is_last = 1'b1;
            end
         end
         STEP_HOLD: begin
            hold    = 1'b1;
            is_last = 1'b1;
         end
         default: is_last = 1'b1;
      endcase
   end

   always_comb begin
      active_in = active_ff;
      step_in   = step_ff;
      if (pop) begin
         active_in = 1'b1;
         step_in   = step_first;
      end else if (advance) begin
         if (is_last) active_in = 1'b0;
         else step_in = step_next;
      end
      if (advance)         rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
      else                 rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= STEP_ERR;
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff      <= step_in;
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) job_ff <= head_msg.job;
      if (advance) begin
         cmd_ff     <= cmd;
         operand_ff <= operand;
         hold_ff    <= hold;
         err_ff     <= err;
         last_ff    <= is_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_BITS - RSP_FIELD_BITS)'(0), operand_ff, cmd_ff};
   assign rsp_tuser  = {err_ff, hold_ff};
   assign rsp_tlast  = last_ff;

`ifndef SYNTHESIS
   a_err_alone: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && err_ff != ERR_NONE) |-> (last_ff && cmd_ff == CMD_CORE && !hold_ff))
      else $error("error result not a lone final word");
   a_start_then_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && cmd_ff == CMD_START_PROG) |-> !last_ff)
      else $error("start programming word closes a run");
   a_hold_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && hold_ff) |-> (last_ff && operand_ff == '0))
      else $error("hold marker not final or not empty");
   a_pop_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (head_msg.valid && (!active_ff || is_last)))
      else $error("job taken while another is in flight");
`endif

endmodule

FILE: rtl/icsp_record_program_sequencer.sv
// Top level of the ICSP record program sequencer: front end, job queue and back end.
// Each job passes from the job queue into the back-end job register, and each result word
// then into the output register. One result word per cycle unless rsp_tready stalls; a
// byte yields one result for an error, ten for a record's first config byte, eight for a
// later config byte and eight or ten for a first code byte.
// Reset (synchronous, active high) clears the queue, the record mode, the output and
// restores config_base to 0x300000 and max_record_length to 32.
module icsp_record_program_sequencer (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // data_byte[7:0], byte_address[29:8], record_length[37:30], zero pad
   input  logic [irps_pkg::REQ_DATA_BITS-1:0]  req_tdata,
   // first_byte
   input  logic                                req_tuser,
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // icsp_command[3:0], icsp_operand[19:4], zero pad
   output logic [irps_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   // hold_for_programming[0], error_code[2:1]
   output logic [irps_pkg::RSP_USER_BITS-1:0]  rsp_tuser,
   output logic                                rsp_tlast,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [irps_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [irps_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import irps_pkg::*;

   job_msg_type push_msg;
   job_msg_type head_msg;
   logic        queue_full;
   logic        pop;

   irps_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .queue_full (queue_full),
      .push_msg   (push_msg)
   );

   irps_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push_msg (push_msg),
      .full     (queue_full),
      .head_msg (head_msg),
      .pop      (pop)
   );

   irps_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_msg   (head_msg),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: bench/icsp_record_program_sequencer_tb.sv
// Self-checking testbench for the ICSP record program sequencer: directed and random records.
module icsp_record_program_sequencer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import irps_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int SETTLE_CYCLES  = 8;
   localparam int LONG_HOLD      = 300;

   typedef struct packed {
      logic [CMD_BITS-1:0]  cmd;
      logic [WORD_BITS-1:0] operand;
      logic                 hold;
      err_type              err;
      logic                 last;
   } icsp_word_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_DATA_BITS-1:0]  req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      req_tlast = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0]  rsp_tdata;
   logic [RSP_USER_BITS-1:0]  rsp_tuser;
   logic                      rsp_tlast;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = REG_CONFIG_BASE;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // predictor state and configuration
   mode_type                 rec_mode = MODE_IDLE;
   logic [BYTE_BITS-1:0]     held_byte = '0;
   logic [CFG_BASE_BITS-1:0] cfg_base = CONFIG_BASE_RESET;
   logic [LENGTH_BITS-1:0]   max_len = MAX_LENGTH_RESET;

   icsp_word_type run_words[$];
   icsp_word_type expected_words[$];

   int  mismatch_count = 0;
   int  live_items = 0;
   int  pending_gap = 0;
   bit  req_valid_high = 1'b0;
   bit  req_idle = 1'b1;
   bit  rsp_idle = 1'b1;
   int  rsp_hold_cycles = 0;
   int  quiet_cycles = 0;

   icsp_record_program_sequencer i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   function automatic void stage_word(logic [CMD_BITS-1:0] cmd, logic [WORD_BITS-1:0] operand,
                                      logic hold, err_type err);
      icsp_word_type w;
      w.cmd     = cmd;
      w.operand = operand;
      w.hold    = hold;
      w.err     = err;
      w.last    = 1'b0;
      run_words.push_back(w);
   endfunction

   // load the upper, high and low table pointer bytes
   function automatic void stage_pointer(logic [ADDRESS_BITS-1:0] a);
      logic [PTR_BITS-1:0] ptr;
      ptr = PTR_BITS'(a);
      stage_word(CMD_CORE, {OP_MOVLW_HIGH, ptr[23:16]}, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, OP_MOVWF_TBLPTRU, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, {OP_MOVLW_HIGH, ptr[15:8]}, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, OP_MOVWF_TBLPTRH, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, {OP_MOVLW_HIGH, ptr[7:0]}, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, OP_MOVWF_TBLPTRL, 1'b0, ERR_NONE);
   endfunction

   function automatic void stage_config_byte(logic [ADDRESS_BITS-1:0] a, logic [7:0] d);
      stage_pointer(a);
      stage_word(CMD_START_PROG, a[0] ? {d, 8'h00} : {8'h00, d}, 1'b0, ERR_NONE);
      stage_word(CMD_CORE, '0, 1'b1, ERR_NONE);
   endfunction

   function automatic void stage_low_byte(logic [7:0] d, logic last);
      if (last) begin
         // no partner byte: pad the high lane
         stage_word(CMD_START_PROG, {PAD_BYTE, d}, 1'b0, ERR_NONE);
         stage_word(CMD_CORE, '0, 1'b1, ERR_NONE);
         rec_mode = MODE_IDLE;
      end else begin
         held_byte = d;
         rec_mode  = MODE_HIGH;
      end
   endfunction

   function automatic void predict_icsp_words(logic [7:0] d, logic [ADDRESS_BITS-1:0] a,
                                              logic [7:0] len, logic first, logic last);
      icsp_word_type w;
      run_words.delete();
      if (first) begin
         rec_mode = MODE_IDLE;
         // an empty record writes nothing
         if (len != 0) begin
            if (len > max_len) begin
               stage_word(CMD_CORE, '0, 1'b0, ERR_TOO_LONG);
            end else if (a >= cfg_base) begin
               stage_word(CMD_CORE, OP_BSF_EECON1_EEPGD, 1'b0, ERR_NONE);
               stage_word(CMD_CORE, OP_BSF_EECON1_CFGS, 1'b0, ERR_NONE);
               stage_config_byte(a, d);
               rec_mode = last ? MODE_IDLE : MODE_CFG;
            end else if (len[0]) begin
               stage_word(CMD_CORE, '0, 1'b0, ERR_ODD_LENGTH);
            end else if (a[0]) begin
               stage_word(CMD_CORE, '0, 1'b0, ERR_ODD_START);
            end else begin
               stage_word(CMD_CORE, OP_BSF_EECON1_EEPGD, 1'b0, ERR_NONE);
               stage_word(CMD_CORE, OP_BCF_EECON1_CFGS, 1'b0, ERR_NONE);
               stage_pointer(a);
               stage_low_byte(d, last);
            end
         end
      end else begin
         case (rec_mode)
            MODE_CFG: begin
               stage_config_byte(a, d);
               if (last)
                  rec_mode = MODE_IDLE;
            end
            MODE_LOW: stage_low_byte(d, last);
            MODE_HIGH: begin
               if (last) begin
                  stage_word(CMD_START_PROG, {d, held_byte}, 1'b0, ERR_NONE);
                  stage_word(CMD_CORE, '0, 1'b1, ERR_NONE);
                  rec_mode = MODE_IDLE;
               end else begin
                  stage_word(CMD_WRITE_POSTINC2, {d, held_byte}, 1'b0, ERR_NONE);
                  rec_mode = MODE_LOW;
               end
            end
            default: ;
         endcase
      end
      foreach (run_words[i]) begin
         w      = run_words[i];
         w.last = (i == run_words.size() - 1);
         expected_words.push_back(w);
      end
   endfunction

   task automatic send_byte(logic [7:0] d, logic [ADDRESS_BITS-1:0] a, logic [7:0] len,
                            logic first, logic last);
      logic [REQ_DATA_BITS-1:0] word;
      word        = '0;
      word[7:0]   = d;
      word[29:8]  = a;
      word[37:30] = len;
      repeat (pending_gap) @(posedge clock);
      req_tvalid     <= 1'b1;
      req_tdata      <= word;
      req_tuser      <= first;
      req_tlast      <= last;
      req_valid_high = 1'b1;
      do @(posedge clock); while (req_tready !== 1'b1);
      if (first || rec_mode != MODE_IDLE)
         live_items++;
      predict_icsp_words(d, a, len, first, last);
      // keep valid up when the next transaction follows straight on
      pending_gap = req_idle ? $urandom_range(9, 0) : 0;
      if (pending_gap > 0) begin
         req_tvalid     <= 1'b0;
         req_valid_high = 1'b0;
      end
   endtask

   task automatic stop_sending();
      if (req_valid_high) begin
         req_tvalid     <= 1'b0;
         req_valid_high = 1'b0;
      end
      pending_gap = 0;
   endtask

   task automatic wait_until_drained();
      do @(posedge clock); while (expected_words.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write both registers back to back; only called with the block idle
   task automatic set_config(logic [CFG_BASE_BITS-1:0] base, logic [LENGTH_BITS-1:0] limit);
      csr_valid <= 1'b1;
      csr_index <= REG_CONFIG_BASE;
      csr_data  <= base;
      do @(posedge clock); while (csr_ready !== 1'b1);
      cfg_base = base;
      csr_index <= REG_MAX_LENGTH;
      csr_data  <= CSR_DATA_BITS'(limit);
      do @(posedge clock); while (csr_ready !== 1'b1);
      max_len = limit;
      csr_valid <= 1'b0;
   endtask

   task automatic test_code_records();
      req_idle = 1'b1;
      rsp_idle = 1'b1;
      // stray byte after reset: ignored
      send_byte(8'h5a, 22'h000000, 8'd4, 1'b0, 1'b0);
      send_byte(8'h00, 22'h000000, 8'd4, 1'b1, 1'b0);
      send_byte(8'hff, 22'h000001, 8'd4, 1'b0, 1'b0);
      send_byte(8'h12, 22'h000002, 8'd4, 1'b0, 1'b0);
      send_byte(8'h34, 22'h000003, 8'd4, 1'b0, 1'b1);
      send_byte(8'hff, 22'h000100, 8'd0, 1'b1, 1'b1);
      // odd length, then a tail that must be dropped
      send_byte(8'h11, 22'h000010, 8'd3, 1'b1, 1'b0);
      send_byte(8'h22, 22'h000011, 8'd3, 1'b0, 1'b1);
      send_byte(8'h44, 22'h000021, 8'd2, 1'b1, 1'b0);
      send_byte(8'h55, 22'h000022, 8'd2, 1'b0, 1'b1);
      send_byte(8'h66, 22'h000040, 8'd33, 1'b1, 1'b0);
      send_byte(8'h77, 22'h000080, 8'd255, 1'b1, 1'b0);
      // lone low byte at the top of code space
      send_byte(8'ha5, 22'h2ffffe, 8'd2, 1'b1, 1'b1);
      // abandon a record halfway through a pair
      send_byte(8'h01, 22'h000200, 8'd6, 1'b1, 1'b0);
      send_byte(8'h02, 22'h000201, 8'd6, 1'b0, 1'b0);
      send_byte(8'h03, 22'h000202, 8'd6, 1'b0, 1'b0);
      send_byte(8'h04, 22'h000300, 8'd2, 1'b1, 1'b0);
      send_byte(8'h05, 22'h000301, 8'd2, 1'b0, 1'b1);
      // run past the stated length without a last mark
      send_byte(8'hc0, 22'h000400, 8'd2, 1'b1, 1'b0);
      send_byte(8'hc1, 22'h000401, 8'd2, 1'b0, 1'b0);
      send_byte(8'hc2, 22'h000402, 8'd2, 1'b0, 1'b0);
      send_byte(8'hc3, 22'h000403, 8'd2, 1'b0, 1'b1);
   endtask

   task automatic test_config_records();
      send_byte(8'h81, 22'h300000, 8'd3, 1'b1, 1'b0);
      send_byte(8'h82, 22'h300001, 8'd3, 1'b0, 1'b0);
      send_byte(8'h83, 22'h300002, 8'd3, 1'b0, 1'b1);
      send_byte(8'hff, 22'h3fffff, 8'd1, 1'b1, 1'b1);
      send_byte(8'h00, 22'h300005, 8'd1, 1'b1, 1'b0);
      send_byte(8'h3c, 22'h300006, 8'd1, 1'b0, 1'b1);
      // length limit is tested before the address
      send_byte(8'h99, 22'h300008, 8'd33, 1'b1, 1'b0);
   endtask

   task automatic test_output_backpressure();
      req_idle = 1'b0;
      rsp_hold_cycles = LONG_HOLD;
      for (int i = 0; i < 6; i++)
         send_byte(8'($urandom), 22'h300010 + 22'(i), 8'd6, i == 0, i == 5);
      req_idle = 1'b1;
   endtask

   task automatic test_sender_pause();
      send_byte(8'h10, 22'h001000, 8'd8, 1'b1, 1'b0);
      send_byte(8'h32, 22'h001001, 8'd8, 1'b0, 1'b0);
      send_byte(8'h54, 22'h001002, 8'd8, 1'b0, 1'b0);
      // hold the rest of the record until every word is out
      stop_sending();
      wait_until_drained();
      for (int i = 3; i < 8; i++)
         send_byte(8'($urandom), 22'h001000 + 22'(i), 8'd8, 1'b0, i == 7);
   endtask

   task automatic test_random_records(int count, logic [CFG_BASE_BITS-1:0] base,
                                      logic [LENGTH_BITS-1:0] limit);
      int                      target;
      int                      kind;
      int                      span;
      int                      cut;
      logic [ADDRESS_BITS-1:0] a;
      stop_sending();
      wait_until_drained();
      set_config(base, limit);
      target = live_items + count;
      while (live_items < target) begin
         kind     = $urandom_range(9, 0);
         req_idle = ($urandom_range(3, 0) != 0);
         rsp_idle = ($urandom_range(3, 0) != 0);
         if (kind <= 3 && cfg_base > 1 && max_len >= 2) begin
            span = 2 * $urandom_range(((max_len > 12) ? 12 : max_len) / 2, 1);
            a    = ADDRESS_BITS'($urandom_range(cfg_base - 1, 0)) & ~22'd1;
            // now and then break the record off without a last mark
            cut  = ($urandom_range(5, 0) == 0) ? $urandom_range(span - 1, 1) : span;
            for (int i = 0; i < cut; i++)
               send_byte(8'($urandom), a + ADDRESS_BITS'(i), 8'(span), i == 0,
                         i == span - 1);
         end else if (kind <= 6 && max_len >= 1) begin
            span = $urandom_range((max_len > 4) ? 4 : max_len, 1);
            a    = ADDRESS_BITS'($urandom_range(22'h3fffff, cfg_base));
            for (int i = 0; i < span; i++)
               send_byte(8'($urandom), a + ADDRESS_BITS'(i), 8'(span), i == 0,
                         i == span - 1);
         end else if (kind == 7) begin
            span = $urandom_range(2, 0);
            a    = ADDRESS_BITS'($urandom);
            send_byte(8'($urandom), a, 8'($urandom_range(255, 1)), 1'b1, span == 0);
            for (int i = 1; i <= span; i++)
               send_byte(8'($urandom), a + ADDRESS_BITS'(i), 8'($urandom), 1'b0, i == span);
         end else begin
            send_byte(8'($urandom), ADDRESS_BITS'($urandom), 8'($urandom),
                      1'($urandom), 1'($urandom));
         end
      end
   endtask

   // result side: random stall per transaction, or one long hold when asked
   initial begin : rsp_sink
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_idle ? $urandom_range(9, 0) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && rsp_tready === 1'b1));
      end
   end

   function automatic void check_field(string name, int unsigned exp, int unsigned act);
      if (exp != act) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp, act);
         mismatch_count++;
      end
   endfunction

   always @(posedge clock) begin : rsp_checker
      icsp_word_type w;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready === 1'b1) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual data %h user %h last %b",
                     $time, rsp_tdata, rsp_tuser, rsp_tlast);
            mismatch_count++;
         end else begin
            w = expected_words.pop_front();
            check_field("icsp_command", w.cmd, rsp_tdata[3:0]);
            check_field("icsp_operand", w.operand, rsp_tdata[19:4]);
            check_field("hold_for_programming", w.hold, rsp_tuser[0]);
            check_field("error_code", w.err, rsp_tuser[2:1]);
            check_field("last_of_run", w.last, rsp_tlast);
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready === 1'b1) || (rsp_tvalid === 1'b1 && rsp_tready)
          || (csr_valid && csr_ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : run_tests
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_code_records();
      test_config_records();
      test_output_backpressure();
      test_sender_pause();
      test_random_records(20, 22'h300000, 8'd32);
      test_random_records(10, 22'h000000, 8'd255);
      test_random_records(8, 22'h3fffff, 8'd0);
      test_random_records(10, 22'h3fffff, 8'd1);
      test_random_records(10, CFG_BASE_BITS'($urandom), 8'($urandom_range(255, 1)));
      stop_sending();
      wait_until_drained();
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
